>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL files; included by the backoff policy unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define RBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define RBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/rbp_pkg.sv
package rbp_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int REG_W      = 22;
    localparam int LIMIT_W    = 4;
    localparam int NOW_W      = 32;
    localparam int JITTER_W   = 12;
    localparam int BACKOFF_W  = 23;
    localparam int COUNT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BACKOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARD_BACKOFF    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_LIMIT      = 2'd3;

    localparam logic [REG_W-1:0]   INITIAL_BACKOFF_RST = 22'd5000;
    localparam logic [REG_W-1:0]   MAX_BACKOFF_RST     = 22'd120000;
    localparam logic [REG_W-1:0]   HARD_BACKOFF_RST    = 22'd30000;
    localparam logic [LIMIT_W-1:0] SOFT_LIMIT_RST      = 4'd3;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_RESTORED = 2'd1,
        ACT_SOFT     = 2'd2,
        ACT_HARD     = 2'd3
    } action_t;

    typedef struct packed {
        logic                link_up;
        logic [NOW_W-1:0]    now_ms;
        logic [JITTER_W-1:0] jitter_ms;
    } in_item_t;

    typedef struct packed {
        action_t              action;
        logic [BACKOFF_W-1:0] backoff_ms;
        logic [COUNT_W-1:0]   soft_count;
    } out_item_t;

endpackage

>>> rtl/core/reconnect_backoff_policy_unit.sv
// Reconnect backoff policy: exponential backoff with jitter for a lost link.
// Each request on the input channel is one poll carrying the link status, a
// millisecond timestamp and a jitter value. Exactly one result request leaves
// the output channel per poll, giving the action taken, the backoff after the
// update and the soft attempt count.
// The block registers the poll, evaluates it against its state and registers
// the result, so a result is presented once its poll has passed from the
// evaluation register into the output register, where it holds until taken.
// One poll is taken in every cycle while the output side keeps up; the rate is
// set by the single state update per cycle in the evaluation stage.
// When the receiver stalls, the result holds and the evaluation stage holds its
// poll. The input channel takes one more poll only if the evaluation stage is
// empty; otherwise its ready drops in the same cycle as the output ready.
// Reset clears the pipeline, returns the link state to down with no retry
// armed, loads the backoff with 5000 ms and returns the four configuration
// registers to 5000, 120000, 30000 and 3. The user must write configuration
// through the write port only while no poll is in flight; nothing enforces it.
`include "assert_macros.svh"

module reconnect_backoff_policy_unit #(
    parameter int TIME_BITS = rbp_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rbp_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rbp_pkg::out_item_t              out_data,
    input  logic                            cfg_wr_en,
    input  logic [rbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rbp_pkg::*;

    localparam int CMP_W = (TIME_BITS > BACKOFF_W) ? TIME_BITS : BACKOFF_W;

    logic [REG_W-1:0]     initial_reg;
    logic [REG_W-1:0]     max_reg;
    logic [REG_W-1:0]     hard_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    logic                 was_up_reg;
    logic                 was_up_next;
    logic [TIME_BITS-1:0] last_try_reg;
    logic [TIME_BITS-1:0] last_try_next;
    logic [BACKOFF_W-1:0] backoff_reg;
    logic [BACKOFF_W-1:0] backoff_next;
    logic [COUNT_W-1:0]   soft_reg;
    logic [COUNT_W-1:0]   soft_next;
    logic                 force_reg;
    logic                 force_next;

    logic                 s1_vld_reg;
    in_item_t             s1_reg;
    logic                 out_vld_reg;
    out_item_t            out_reg;
    out_item_t            result;

    logic                 advance;
    logic                 step_en;

    logic [TIME_BITS+NOW_W-1:0] now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic                 dropped;
    logic [TIME_BITS-1:0] last_eff;
    logic [COUNT_W-1:0]   soft_eff;
    logic                 force_eff;
    logic [TIME_BITS-1:0] elapsed;
    logic                 due;
    logic [BACKOFF_W:0]   doubled;
    logic [BACKOFF_W:0]   max_ext;
    logic [BACKOFF_W:0]   capped;
    logic [BACKOFF_W-1:0] grown;
    logic                 go_hard;

    assign advance   = !out_vld_reg || out_ready;
    assign in_ready  = !s1_vld_reg || advance;
    assign step_en   = s1_vld_reg && advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_reg <= INITIAL_BACKOFF_RST;
            max_reg     <= MAX_BACKOFF_RST;
            hard_reg    <= HARD_BACKOFF_RST;
            limit_reg   <= SOFT_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INITIAL_BACKOFF: initial_reg <= cfg_data;
                CFG_MAX_BACKOFF:     max_reg     <= cfg_data;
                CFG_HARD_BACKOFF:    hard_reg    <= cfg_data;
                CFG_SOFT_LIMIT:      limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:             limit_reg   <= limit_reg;
            endcase
        end
    end

    assign now_wide  = {{TIME_BITS{1'b0}}, s1_reg.now_ms};
    assign now_t     = now_wide[TIME_BITS-1:0];
    assign dropped   = was_up_reg && !s1_reg.link_up;
    assign last_eff  = dropped ? now_t : last_try_reg;
    assign soft_eff  = dropped ? '0 : soft_reg;
    assign force_eff = dropped || force_reg;
    assign elapsed   = now_t - last_eff;
    assign due       = force_eff || (CMP_W'(elapsed) >= CMP_W'(backoff_reg));
    assign doubled   = {backoff_reg, 1'b0};
    assign max_ext   = (BACKOFF_W + 1)'(max_reg);
    assign capped    = (doubled > max_ext) ? max_ext : doubled;
    assign grown     = BACKOFF_W'(capped + (BACKOFF_W + 1)'(s1_reg.jitter_ms));
    assign go_hard   = (soft_eff >= limit_reg) || (backoff_reg >= BACKOFF_W'(hard_reg));

    always_comb
    begin
        was_up_next   = s1_reg.link_up;
        last_try_next = last_eff;
        backoff_next  = backoff_reg;
        soft_next     = soft_eff;
        force_next    = force_eff;
        result.action = ACT_NONE;
        if (s1_reg.link_up)
        begin
            if (!was_up_reg)
            begin
                result.action = ACT_RESTORED;
                backoff_next  = BACKOFF_W'(initial_reg);
                soft_next     = '0;
                force_next    = 1'b0;
            end
        end
        else if (due)
        begin
            last_try_next = now_t;
            if (go_hard)
            begin
                result.action = ACT_HARD;
                soft_next     = '0;
            end
            else
            begin
                result.action = ACT_SOFT;
                soft_next     = soft_eff + COUNT_W'(1);
            end
            force_next = 1'b0;
            if (backoff_reg < BACKOFF_W'(max_reg))
            begin
                backoff_next = grown;
            end
        end
        result.backoff_ms = backoff_next;
        result.soft_count = soft_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_up_reg   <= 1'b0;
            last_try_reg <= '0;
            backoff_reg  <= BACKOFF_W'(INITIAL_BACKOFF_RST);
            soft_reg     <= '0;
            force_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            was_up_reg   <= was_up_next;
            last_try_reg <= last_try_next;
            backoff_reg  <= backoff_next;
            soft_reg     <= soft_next;
            force_reg    <= force_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg <= in_data;
        end
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    // A soft retry always leaves a nonzero count; a hard reset or restore clears it.
    `RBP_ASSERT(a_soft_count_nonzero,
        (out_vld_reg && out_reg.action == ACT_SOFT) |-> (out_reg.soft_count != '0),
        "soft retry reported with a zero soft count")
    `RBP_ASSERT(a_count_cleared,
        (out_vld_reg && (out_reg.action == ACT_HARD || out_reg.action == ACT_RESTORED))
            |-> (out_reg.soft_count == '0),
        "hard reset or restore left a nonzero soft count")
    `RBP_ASSERT(a_stage_holds,
        (s1_vld_reg && !advance) |=> (s1_vld_reg && $stable(s1_reg)),
        "evaluation stage lost its request during a stall")
    `RBP_ASSERT(a_no_attempt_while_up,
        (step_en && s1_reg.link_up) |=> (out_reg.action == ACT_NONE
            || out_reg.action == ACT_RESTORED),
        "retry attempted while the link is up")

endmodule
